// ----- rtl/core/atr_bpt_pkg.sv -----
// Package for the ATR breakout position tracker: field widths, event and
// position codes, configuration register indexes and fixed scale constants.
// No dependencies.
`timescale 1ns / 1ps

package atr_bpt_pkg;

  // Fixed field widths
  localparam int PRICE_W = 32;
  localparam int PER_CFG_W = 7;
  localparam int MULT_W = 16;
  localparam int EQ_W = 40;
  localparam int DD_W = 39;
  localparam int CNT_W = 32;
  localparam int PNL_W = 32;

  // Shared divider dividend width and breakout compare width
  localparam int DIV_W = 48;
  localparam int CMP_W = 64;

  // Basis point scale
  localparam logic [13:0] BP_SCALE = 14'd10000;

  // Trade event codes
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_ENTER_LONG = 3'd1;
  localparam logic [2:0] EV_ENTER_SHORT = 3'd2;
  localparam logic [2:0] EV_CLOSE_LONG = 3'd3;
  localparam logic [2:0] EV_CLOSE_SHORT = 3'd4;

  // Position codes
  localparam logic [1:0] POS_FLAT = 2'd0;
  localparam logic [1:0] POS_LONG = 2'd1;
  localparam logic [1:0] POS_SHORT = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_MULT = 1'b1;

  // Configuration reset values
  localparam logic [PER_CFG_W-1:0] PERIOD_RST = 7'd14;
  localparam logic [MULT_W-1:0] MULT_RST = 16'd512;

endpackage

// ----- rtl/core/atr_breakout_position_tracker_unit.sv -----
// ATR breakout position tracker: true range window, shared restoring divider,
// breakout compare, position machine and equity / drawdown bookkeeping.
// Depends on atr_bpt_pkg.
// One candle at a time, set by the window summing loop and the 48-step shared
// divider (the profit divide is skipped at zero entry price), and a stalled output
// item holds the block until it is taken.
// Reset (synchronous, rst_n low) returns all state and both registers to
// their defaults, then a clearing pass zeroes all MAX_PERIOD entries of the
// window memory; no candle is taken during it, configuration writes are.
`timescale 1ns / 1ps

module atr_breakout_position_tracker_unit #(
  parameter int MAX_PERIOD = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [atr_bpt_pkg::PRICE_W-1:0]     in_candle_high,
  input  logic [atr_bpt_pkg::PRICE_W-1:0]     in_candle_low,
  input  logic [atr_bpt_pkg::PRICE_W-1:0]     in_candle_close,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_trade_event,
  output logic [1:0]                          out_position_now,
  output logic [atr_bpt_pkg::PRICE_W-1:0]     out_atr_value,
  output logic signed [atr_bpt_pkg::PNL_W-1:0] out_trade_result_bp,
  output logic signed [atr_bpt_pkg::EQ_W-1:0] out_equity_bp,
  output logic [atr_bpt_pkg::DD_W-1:0]        out_max_drawdown_bp,
  output logic [atr_bpt_pkg::CNT_W-1:0]       out_trade_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [atr_bpt_pkg::MULT_W-1:0]      cfg_data
);
  import atr_bpt_pkg::*;

  localparam int PTR_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int PER_W = $clog2(MAX_PERIOD + 1);
  localparam int SUM_W = PRICE_W + PER_W;
  localparam int EQX_W = EQ_W + 1;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_PERIOD - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_SUM   = 11'b00000000100,
    S_DIVA  = 11'b00000001000,
    S_MUL   = 11'b00000010000,
    S_DEC   = 11'b00000100000,
    S_PLD   = 11'b00001000000,
    S_DIVP  = 11'b00010000000,
    S_PSAT  = 11'b00100000000,
    S_BOOK  = 11'b01000000000,
    S_DD    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [PER_CFG_W-1:0] cfg_period_r;
  logic [MULT_W-1:0]    cfg_mult_r;

  // Tracker state
  logic [PTR_W-1:0]       clr_r;
  logic [PTR_W-1:0]       ptr_r;
  logic [PRICE_W-1:0]     prev_r;
  logic [CNT_W-1:0]       seen_r;
  logic [1:0]             pos_r;
  logic [PRICE_W-1:0]     entry_r;
  logic signed [EQ_W-1:0] eq_r;
  logic signed [EQ_W-1:0] peak_r;
  logic [DD_W-1:0]        worst_r;
  logic [CNT_W-1:0]       opened_r;

  // Per-candle working registers
  logic [PRICE_W-1:0]      cl_r;
  logic [PTR_W-1:0]        rd_addr_r;
  logic [PRICE_W-1:0]      rd_data_r;
  logic [PER_W-1:0]        rd_cnt_r;
  logic                    pend_r;
  logic [SUM_W-1:0]        sum_r;
  logic [PRICE_W-1:0]      atr_r;
  logic signed [CMP_W-1:0] lhs_r;
  logic signed [CMP_W-1:0] rhs_r;
  logic [2:0]              ev_r;
  logic signed [PNL_W-1:0] profit_r;
  logic                    neg_r;
  logic [DIV_W-1:0]        num_r;

  // Shared divider
  logic [PRICE_W-1:0] rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [PRICE_W-1:0] dvs_r;
  logic [DCNT_W-1:0]  dcnt_r;

  // Output register
  logic                    out_valid_r;
  logic [2:0]              out_ev_r;
  logic [1:0]              out_pos_r;
  logic [PRICE_W-1:0]      out_atr_r;
  logic signed [PNL_W-1:0] out_pnl_r;
  logic signed [EQ_W-1:0]  out_eq_r;
  logic [DD_W-1:0]         out_dd_r;
  logic [CNT_W-1:0]        out_cnt_r;

  // Window memory
  logic [PRICE_W-1:0] win_mem [MAX_PERIOD];
  logic               mem_we;
  logic [PTR_W-1:0]   mem_wa;
  logic [PRICE_W-1:0] mem_wd;

  // Combinational helpers
  int                        per_tmp;
  logic [PER_W-1:0]          per_eff;
  logic                      warm_done;
  logic                      in_acc;
  logic                      out_load;
  logic [PRICE_W-1:0]        tr;
  logic [PRICE_W-1:0]        t_hl;
  logic [PRICE_W-1:0]        t_hp;
  logic [PRICE_W-1:0]        t_lp;
  logic [PRICE_W:0]          div_sh;
  logic [PRICE_W:0]          div_diff;
  logic                      div_ge;
  logic signed [PRICE_W:0]   d_s;
  logic signed [PRICE_W+PER_W+1:0] lhs_mul;
  logic [MULT_W+SUM_W-1:0]   rhs_mul;
  logic                      up;
  logic                      dn;
  logic [PRICE_W-1:0]        mag;
  logic                      mag_neg;
  logic [PRICE_W+13:0]       num_mul;
  logic signed [EQX_W-1:0]   eq_sum;
  logic signed [EQ_W-1:0]    eq_sat;
  logic signed [EQ_W-1:0]    pk;
  logic signed [EQX_W-1:0]   dd;
  logic [DD_W-1:0]           dd_sat;
  logic signed [PNL_W-1:0]   pnl_sat;

  // Clamp the period to 1..MAX_PERIOD
  always_comb begin
    per_tmp = int'(cfg_period_r);
    if (per_tmp == 0) begin
      per_tmp = 1;
    end else if (per_tmp > MAX_PERIOD) begin
      per_tmp = MAX_PERIOD;
    end
    per_eff = PER_W'(per_tmp);
  end

  assign warm_done = (seen_r >= CNT_W'(per_eff));
  assign in_acc = in_valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_IDLE) ? 1'b0 : 1'b0;

  // True range of the incoming candle
  always_comb begin
    t_hl = (in_candle_high >= in_candle_low) ? (in_candle_high - in_candle_low) : '0;
    t_hp = (in_candle_high >= prev_r) ? (in_candle_high - prev_r) : (prev_r - in_candle_high);
    t_lp = (in_candle_low >= prev_r) ? (in_candle_low - prev_r) : (prev_r - in_candle_low);
    tr = t_hl;
    if (seen_r != '0) begin
      if (t_hp > tr) begin
        tr = t_hp;
      end
      if (t_lp > tr) begin
        tr = t_lp;
      end
    end
  end

  // Window write port: clearing pass or new true range
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r;
    mem_wd = tr;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (in_acc) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= win_mem[rd_addr_r];
  end

  // Shared divider step: one quotient bit a cycle
  always_comb begin
    div_sh = {rem_r, quo_r[DIV_W-1]};
    div_diff = div_sh - {1'b0, dvs_r};
    div_ge = (div_sh >= {1'b0, dvs_r});
  end

  // Breakout products and trade move
  always_comb begin
    d_s = $signed({1'b0, cl_r}) - $signed({1'b0, prev_r});
    lhs_mul = d_s * $signed({1'b0, per_eff});
    rhs_mul = cfg_mult_r * sum_r;
    up = (lhs_r > rhs_r);
    dn = (lhs_r < -rhs_r);
    if (cl_r >= entry_r) begin
      mag = cl_r - entry_r;
      mag_neg = 1'b0;
    end else begin
      mag = entry_r - cl_r;
      mag_neg = 1'b1;
    end
    if (pos_r == POS_SHORT) begin
      mag_neg = ~mag_neg;
    end
    num_mul = mag * BP_SCALE;
  end

  // Saturate the divided profit, equity and drawdown
  always_comb begin
    if (!neg_r) begin
      pnl_sat = (quo_r > DIV_W'(32'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
                                                : $signed(quo_r[PNL_W-1:0]);
    end else begin
      pnl_sat = (quo_r > DIV_W'(32'h8000_0000)) ? $signed(32'h8000_0000)
                                                : $signed(-quo_r[PNL_W-1:0]);
    end
    eq_sum = EQX_W'(eq_r) + EQX_W'(profit_r);
    if (eq_sum[EQX_W-1] != eq_sum[EQ_W-1]) begin
      eq_sat = eq_sum[EQX_W-1] ? {1'b1, {(EQ_W-1){1'b0}}} : {1'b0, {(EQ_W-1){1'b1}}};
    end else begin
      eq_sat = eq_sum[EQ_W-1:0];
    end
    pk = (eq_r > peak_r) ? eq_r : peak_r;
    dd = EQX_W'(pk) - EQX_W'(eq_r);
    dd_sat = (dd[EQX_W-1:DD_W] != '0) ? {DD_W{1'b1}} : dd[DD_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == LAST_PTR) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_SUM;
      S_SUM: begin
        if ((rd_cnt_r == per_eff) && !pend_r) begin
          state_nxt = warm_done ? S_DIVA : S_DD;
        end
      end
      S_DIVA:  if (dcnt_r == DIV_LAST) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = S_DD;
        if (sum_r != '0) begin
          if (((pos_r == POS_LONG) && dn) || ((pos_r == POS_SHORT) && up)) begin
            state_nxt = (entry_r == '0) ? S_BOOK : S_PLD;
          end
        end
      end
      S_PLD:   state_nxt = S_DIVP;
      S_DIVP:  if (dcnt_r == DIV_LAST) state_nxt = S_PSAT;
      S_PSAT:  state_nxt = S_BOOK;
      S_BOOK:  state_nxt = S_DD;
      S_DD:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      ptr_r        <= '0;
      prev_r       <= '0;
      seen_r       <= '0;
      pos_r        <= POS_FLAT;
      entry_r      <= '0;
      eq_r         <= '0;
      peak_r       <= '0;
      worst_r      <= '0;
      opened_r     <= '0;
      out_valid_r  <= 1'b0;
      cfg_period_r <= PERIOD_RST;
      cfg_mult_r   <= MULT_RST;
    end else begin
      state_r <= state_nxt;

      // Take configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PERIOD: cfg_period_r <= cfg_data[PER_CFG_W-1:0];
          CFG_MULT:   cfg_mult_r <= cfg_data;
          default:    ;
        endcase
      end

      // Raise the output item when the candle closes, drop it once taken
      if ((state_r == S_DD) && (state_nxt == S_IDLE)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_SUM: begin
          if ((rd_cnt_r == per_eff) && !pend_r) begin
            ptr_r <= (ptr_r == LAST_PTR) ? '0 : ptr_r + 1'b1;
          end
        end
        S_DEC: begin
          if (sum_r != '0) begin
            case (pos_r)
              POS_FLAT: begin
                if (up || dn) begin
                  pos_r   <= up ? POS_LONG : POS_SHORT;
                  entry_r <= cl_r;
                  if (opened_r != {CNT_W{1'b1}}) begin
                    opened_r <= opened_r + 1'b1;
                  end
                end
              end
              POS_LONG:  if (dn) pos_r <= POS_FLAT;
              POS_SHORT: if (up) pos_r <= POS_FLAT;
              default:   ;
            endcase
          end
        end
        S_BOOK: eq_r <= eq_sat;
        S_DD: begin
          if (state_nxt == S_IDLE) begin
            // Close the candle and advance history
            peak_r      <= pk;
            if (dd_sat > worst_r) begin
              worst_r <= dd_sat;
            end
            prev_r      <= cl_r;
            if (seen_r != {CNT_W{1'b1}}) begin
              seen_r <= seen_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cl_r      <= in_candle_close;
        rd_addr_r <= ptr_r;
        rd_cnt_r  <= '0;
        pend_r    <= 1'b0;
        sum_r     <= '0;
        atr_r     <= '0;
        ev_r      <= EV_NONE;
        profit_r  <= '0;
      end
      S_SUM: begin
        // Walk back through the newest P ranges
        if (rd_cnt_r != per_eff) begin
          pend_r    <= 1'b1;
          rd_cnt_r  <= rd_cnt_r + 1'b1;
          rd_addr_r <= (rd_addr_r == '0) ? LAST_PTR : rd_addr_r - 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (pend_r) begin
          sum_r <= sum_r + SUM_W'(rd_data_r);
        end
        if ((rd_cnt_r == per_eff) && !pend_r) begin
          quo_r  <= DIV_W'(sum_r);
          rem_r  <= '0;
          dvs_r  <= PRICE_W'(per_eff);
          dcnt_r <= '0;
        end
      end
      S_DIVA, S_DIVP: begin
        rem_r  <= div_ge ? div_diff[PRICE_W-1:0] : div_sh[PRICE_W-1:0];
        quo_r  <= {quo_r[DIV_W-2:0], div_ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
      S_MUL: begin
        atr_r <= quo_r[PRICE_W-1:0];
        lhs_r <= CMP_W'(lhs_mul) <<< 8;
        rhs_r <= $signed(CMP_W'(rhs_mul));
      end
      S_DEC: begin
        num_r <= DIV_W'(num_mul);
        neg_r <= mag_neg;
        if (sum_r != '0) begin
          case (pos_r)
            POS_FLAT: begin
              if (up) begin
                ev_r <= EV_ENTER_LONG;
              end else if (dn) begin
                ev_r <= EV_ENTER_SHORT;
              end
            end
            POS_LONG:  if (dn) ev_r <= EV_CLOSE_LONG;
            POS_SHORT: if (up) ev_r <= EV_CLOSE_SHORT;
            default:   ;
          endcase
          // Zero entry price: saturate by the direction of the move
          if (((pos_r == POS_LONG) && dn) || ((pos_r == POS_SHORT) && up)) begin
            if (mag == '0) begin
              profit_r <= '0;
            end else begin
              profit_r <= mag_neg ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
            end
          end
        end
      end
      S_PLD: begin
        quo_r  <= num_r;
        rem_r  <= '0;
        dvs_r  <= entry_r;
        dcnt_r <= '0;
      end
      S_PSAT: profit_r <= pnl_sat;
      S_DD: begin
        if (state_nxt == S_IDLE) begin
          out_ev_r  <= ev_r;
          out_pos_r <= pos_r;
          out_atr_r <= atr_r;
          out_pnl_r <= profit_r;
          out_eq_r  <= eq_r;
          out_dd_r  <= (dd_sat > worst_r) ? dd_sat : worst_r;
          out_cnt_r <= opened_r;
        end
      end
      default: ;
    endcase
  end

  // Ports
  assign in_stall            = (state_r != S_IDLE) || out_load;
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_trade_event     = out_ev_r;
  assign out_position_now    = out_pos_r;
  assign out_atr_value       = out_atr_r;
  assign out_trade_result_bp = out_pnl_r;
  assign out_equity_bp       = out_eq_r;
  assign out_max_drawdown_bp = out_dd_r;
  assign out_trade_count     = out_cnt_r;

`ifndef SYNTHESIS
  // An entry event leaves the matching position open
  a_enter_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_trade_event == EV_ENTER_LONG) |-> out_position_now == POS_LONG)
    else $error("enter long without long position");

  a_enter_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_trade_event == EV_ENTER_SHORT) |-> out_position_now == POS_SHORT)
    else $error("enter short without short position");

  // A close event leaves the book flat
  a_close_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_trade_event == EV_CLOSE_LONG) || (out_trade_event == EV_CLOSE_SHORT))
    |-> out_position_now == POS_FLAT)
    else $error("close event without flat position");

  // Worst drawdown never shrinks
  a_dd_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(rst_n, 2) |-> worst_r >= $past(worst_r))
    else $error("max drawdown decreased");
`endif

endmodule
